// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk outside reset.
`define CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next one.
`define CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rspa_pkg.sv -----
// ---------------------------------------------------------------------------
// rspa_pkg
// Types and constants shared by the request slot arbiter cells and top level.
// ---------------------------------------------------------------------------
package rspa_pkg;

	localparam int SLOT_COUNT_DEF  = 8;
	localparam int SOURCE_BITS_DEF = 4;

	localparam int TORQUE_BITS   = 16;
	localparam int TIME_BITS     = 32;
	localparam int TIMEOUT_BITS  = 16;
	localparam int IDLE_BITS     = 4;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd500;
	localparam logic [IDLE_BITS-1:0]    IDLE_RESET    = 4'd15;

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_EXPIRE = 2'd2
	} op_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT     = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_SOURCE = 1'd1;

	// Control part of the request token that walks the row of slot cells.
	typedef struct packed {
		logic valid;
		op_t  op;
		logic taken;
		logic best_valid;
	} tok_ctl_t;

endpackage

// ----- rtl/rspa_cell.sv -----
// ---------------------------------------------------------------------------
// rspa_cell
// One request slot. Applies the passing request to its slot and folds the
// slot into the running lowest-source winner before handing the token on.
// ---------------------------------------------------------------------------
module rspa_cell #(
	parameter int SOURCE_BITS = rspa_pkg::SOURCE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    adv,
	input  logic [rspa_pkg::TIMEOUT_BITS-1:0]       timeout,
	input  rspa_pkg::tok_ctl_t                      ctl_in,
	input  logic [SOURCE_BITS-1:0]                  src_in,
	input  logic signed [rspa_pkg::TORQUE_BITS-1:0] trq_in,
	input  logic [rspa_pkg::TIME_BITS-1:0]          time_in,
	input  logic [SOURCE_BITS-1:0]                  best_src_in,
	input  logic signed [rspa_pkg::TORQUE_BITS-1:0] best_trq_in,
	output rspa_pkg::tok_ctl_t                      ctl_q,
	output logic [SOURCE_BITS-1:0]                  src_q,
	output logic signed [rspa_pkg::TORQUE_BITS-1:0] trq_q,
	output logic [rspa_pkg::TIME_BITS-1:0]          time_q,
	output logic [SOURCE_BITS-1:0]                  best_src_q,
	output logic signed [rspa_pkg::TORQUE_BITS-1:0] best_trq_q
);

	logic                                    active_q;
	logic [SOURCE_BITS-1:0]                  slot_src_q;
	logic signed [rspa_pkg::TORQUE_BITS-1:0] slot_trq_q;
	logic [rspa_pkg::TIME_BITS-1:0]          slot_stamp_q;

	logic                                    same_src;
	logic                                    hit;
	logic                                    clr;
	logic                                    expire;
	logic [rspa_pkg::TIME_BITS-1:0]          age;
	logic                                    act_d;
	logic [SOURCE_BITS-1:0]                  src_d;
	logic signed [rspa_pkg::TORQUE_BITS-1:0] trq_d;
	logic                                    better;
	logic                                    step;

	assign step     = adv & ctl_in.valid;
	assign same_src = (slot_src_q == src_in);
	assign age      = time_in - slot_stamp_q;

	assign hit    = (ctl_in.op == rspa_pkg::OP_SUBMIT) & ~ctl_in.taken & (~active_q | same_src);
	assign clr    = (ctl_in.op == rspa_pkg::OP_CLEAR) & active_q & same_src;
	assign expire = (ctl_in.op == rspa_pkg::OP_EXPIRE) & active_q
		& (age > {{(rspa_pkg::TIME_BITS-rspa_pkg::TIMEOUT_BITS){1'b0}}, timeout});

	always_comb begin
		act_d = active_q;
		src_d = slot_src_q;
		trq_d = slot_trq_q;
		if (hit) begin
			act_d = 1'b1;
			src_d = src_in;
			trq_d = trq_in;
		end else if (clr | expire) begin
			act_d = 1'b0;
		end
	end

	// Strict compare keeps the lower slot index on equal sources.
	assign better = act_d & (~ctl_in.best_valid | (src_d < best_src_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ctl_q    <= '0;
		end else if (adv) begin
			ctl_q.valid      <= ctl_in.valid;
			ctl_q.op         <= ctl_in.op;
			ctl_q.taken      <= ctl_in.taken | hit;
			ctl_q.best_valid <= ctl_in.best_valid | better;
			if (ctl_in.valid) begin
				active_q <= act_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			slot_src_q <= src_d;
			slot_trq_q <= trq_d;
			if (hit) begin
				slot_stamp_q <= time_in;
			end
		end
		if (adv) begin
			src_q      <= src_in;
			trq_q      <= trq_in;
			time_q     <= time_in;
			best_src_q <= better ? src_d : best_src_in;
			best_trq_q <= better ? trq_d : best_trq_in;
		end
	end

endmodule

// ----- rtl/request_slot_priority_arbiter.sv -----
// ---------------------------------------------------------------------------
// request_slot_priority_arbiter
// A request passes one input register, one cell per slot and one output
// register before its result is valid. One request is in the cell row at a
// time, so a new request is taken only after the last one leaves the row;
// the next request is taken while the result waits. Reset clears all slot
// active bits and the control state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module request_slot_priority_arbiter #(
	parameter int SLOT_COUNT  = rspa_pkg::SLOT_COUNT_DEF,
	parameter int SOURCE_BITS = rspa_pkg::SOURCE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [rspa_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [rspa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [1:0]                              op,
	input  logic [SOURCE_BITS-1:0]                  source,
	input  logic signed [rspa_pkg::TORQUE_BITS-1:0] demanded_torque,
	input  logic [rspa_pkg::TIME_BITS-1:0]          time_ms,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    accepted,
	output logic                                    winner_valid,
	output logic [SOURCE_BITS-1:0]                  winner_source,
	output logic signed [rspa_pkg::TORQUE_BITS-1:0] winner_torque
);

	logic [rspa_pkg::TIMEOUT_BITS-1:0] timeout_q;
	logic [rspa_pkg::IDLE_BITS-1:0]    idle_src_q;
	logic                              busy_q;
	logic                              out_valid_q;
	logic                              adv;
	logic                              in_fire;
	logic                              done;

	rspa_pkg::tok_ctl_t                      head_ctl_q;
	logic [SOURCE_BITS-1:0]                  head_src_q;
	logic signed [rspa_pkg::TORQUE_BITS-1:0] head_trq_q;
	logic [rspa_pkg::TIME_BITS-1:0]          head_time_q;

	rspa_pkg::tok_ctl_t                      tok_ctl  [SLOT_COUNT+1];
	logic [SOURCE_BITS-1:0]                  tok_src  [SLOT_COUNT+1];
	logic signed [rspa_pkg::TORQUE_BITS-1:0] tok_trq  [SLOT_COUNT+1];
	logic [rspa_pkg::TIME_BITS-1:0]          tok_time [SLOT_COUNT+1];
	logic [SOURCE_BITS-1:0]                  tok_bsrc [SLOT_COUNT+1];
	logic signed [rspa_pkg::TORQUE_BITS-1:0] tok_btrq [SLOT_COUNT+1];
	logic [SLOT_COUNT:0]                     tok_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= rspa_pkg::TIMEOUT_RESET;
			idle_src_q <= rspa_pkg::IDLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rspa_pkg::REG_TIMEOUT:     timeout_q  <= cfg_data;
				rspa_pkg::REG_IDLE_SOURCE: idle_src_q <= cfg_data[rspa_pkg::IDLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy_q;
	assign in_fire  = in_valid & ~busy_q;
	assign done     = tok_ctl[SLOT_COUNT].valid & adv;

	// The row freezes only when a finished request meets a full, stalled output.
	assign adv = ~(tok_ctl[SLOT_COUNT].valid & out_valid_q & out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			head_ctl_q <= '0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (in_fire) begin
				head_ctl_q.valid      <= 1'b1;
				head_ctl_q.op         <= rspa_pkg::op_t'(op);
				head_ctl_q.taken      <= 1'b0;
				head_ctl_q.best_valid <= 1'b0;
			end else if (adv) begin
				head_ctl_q.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			head_src_q  <= source;
			head_trq_q  <= demanded_torque;
			head_time_q <= time_ms;
		end
	end

	assign tok_ctl[0]  = head_ctl_q;
	assign tok_src[0]  = head_src_q;
	assign tok_trq[0]  = head_trq_q;
	assign tok_time[0] = head_time_q;
	assign tok_bsrc[0] = '0;
	assign tok_btrq[0] = '0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		rspa_cell #(
			.SOURCE_BITS(SOURCE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.timeout    (timeout_q),
			.ctl_in     (tok_ctl[i]),
			.src_in     (tok_src[i]),
			.trq_in     (tok_trq[i]),
			.time_in    (tok_time[i]),
			.best_src_in(tok_bsrc[i]),
			.best_trq_in(tok_btrq[i]),
			.ctl_q      (tok_ctl[i+1]),
			.src_q      (tok_src[i+1]),
			.trq_q      (tok_trq[i+1]),
			.time_q     (tok_time[i+1]),
			.best_src_q (tok_bsrc[i+1]),
			.best_trq_q (tok_btrq[i+1])
		);
	end

	for (genvar i = 0; i <= SLOT_COUNT; i++) begin : g_vld
		assign tok_vld[i] = tok_ctl[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q & ~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			accepted     <= tok_ctl[SLOT_COUNT].taken;
			winner_valid <= tok_ctl[SLOT_COUNT].best_valid;
			if (tok_ctl[SLOT_COUNT].best_valid) begin
				winner_source <= tok_bsrc[SLOT_COUNT];
				winner_torque <= tok_btrq[SLOT_COUNT];
			end else begin
				winner_source <= SOURCE_BITS'(idle_src_q);
				winner_torque <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CHECK_ALWAYS(a_one_in_flight, $countones(tok_vld) <= 1, "more than one request in the cell row")
	`CHECK_ALWAYS(a_busy_tracks_row, busy_q == (|tok_vld), "busy flag disagrees with the cell row")
	`CHECK_NEXT(a_done_loads_out, done, out_valid_q, "finished request did not reach the output")
	`CHECK_ALWAYS(a_idle_zero_torque, !(out_valid_q && !winner_valid) || winner_torque == '0, "idle result carries torque")

endmodule
